>>> rtl/core/s256hx_pkg.sv
// shared constants, types and functions of the sha-256 hex digest core
package s256hx_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int COUNT_W = 61;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      hex_ascii = (nib < 4'd10) ? (7'h30 + {3'd0, nib}) : (7'h57 + {3'd0, nib});
   endfunction

endpackage

>>> rtl/core/sha256_hex_digest_core.sv
// top level of the streaming sha-256 engine with hex digest output
//
// req channel: one word per byte; tdata = data_byte, tuser[0] = byte_present,
// tlast = message_end. rsp channel: tdata = hex_char, tlast = last_char.
// a byte that does not fill the block is written straight into the block
// buffer. the 64th byte of a block starts a compression: a load step, the
// rounds through one shared round unit and an add step; req_tready is low
// meanwhile. a word with tlast pads the block (up to 64 pad bytes) and
// compresses once or twice, then sends 64 digest words, one per cycle while
// rsp_tready is high. a stalled receiver holds the current digest word and
// the block stays busy until the last word is taken. on a new message the
// state is back at the initial hash value. reset clears control state and the
// count and loads the initial hash; the block buffer is not cleared.
module sha256_hex_digest_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic [0:0] req_tuser,   // byte_present
   input  logic       req_tlast,   // message_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // hex_char, bit 7 zero
   output logic       rsp_tlast    // last_char
);

   s256hx_pkg::state_type state_ff, state_in;
   logic [31:0] h_ff [8], h_in [8];
   logic [31:0] v_ff [8], v_in [8];
   logic [31:0] w_ff [16], w_in [16];
   logic [s256hx_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [5:0]  pos_ff, pos_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;
   logic        two_ff, two_in;
   // set when the block in flight is the final one of a message
   logic        emit_pending_ff, emit_pending_in;
   logic        bwe;
   logic [5:0]  baddr;
   logic [7:0]  bdata;
   logic [63:0] bits;
   logic [31:0] wr, s0, s1, t1, t2;
   logic [31:0] emit_word;
   logic [3:0]  emit_nib;

   assign bits = {cnt_ff, 3'b000};
   assign req_tready = (state_ff == s256hx_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == s256hx_pkg::ST_EMIT);
   assign emit_word = h_ff[rnd_ff[5:3]];
   assign emit_nib = 4'(emit_word >> (5'd28 - {rnd_ff[2:0], 2'b00}));
   assign rsp_tdata = {1'b0, s256hx_pkg::hex_ascii(emit_nib)};
   assign rsp_tlast = (rnd_ff[5:0] == 6'd63);

   // shared round unit
   always_comb begin
      s0 = s256hx_pkg::ror(w_ff[1], 7) ^ s256hx_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = s256hx_pkg::ror(w_ff[14], 17) ^ s256hx_pkg::ror(w_ff[14], 19)
         ^ (w_ff[14] >> 10);
      wr = (rnd_ff < 7'd16) ? w_ff[0] : (w_ff[0] + s0 + w_ff[9] + s1);
      t1 = v_ff[7] + (s256hx_pkg::ror(v_ff[4], 6) ^ s256hx_pkg::ror(v_ff[4], 11)
         ^ s256hx_pkg::ror(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + s256hx_pkg::ROUND_K[rnd_ff[5:0]] + wr;
      t2 = (s256hx_pkg::ror(v_ff[0], 2) ^ s256hx_pkg::ror(v_ff[0], 13)
         ^ s256hx_pkg::ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      two_in = two_ff;
      h_in = h_ff;
      v_in = v_ff;
      w_in = w_ff;
      bwe = 1'b0;
      baddr = pos_ff;
      bdata = req_tdata;
      case (state_ff)
         s256hx_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  bwe = 1'b1;
                  baddr = cnt_ff[5:0];
                  cnt_in = cnt_ff + 1'b1;
               end
               fin_in = req_tlast;
               pos_in = cnt_in[5:0];
               if (req_tuser[0] && cnt_ff[5:0] == 6'd63) begin
                  state_in = s256hx_pkg::ST_LOAD;
               end else if (req_tlast) begin
                  state_in = s256hx_pkg::ST_PAD;
                  two_in = (cnt_in[5:0] >= 6'd56);
               end
            end
         end
         s256hx_pkg::ST_PAD: begin
            // walk pad bytes: 0x80 at fill, zeros, length at the tail
            bwe = 1'b1;
            baddr = pos_ff;
            if (pos_ff == cnt_ff[5:0] && fin_ff) begin
               bdata = s256hx_pkg::PAD_BYTE;
            end else if (pos_ff >= 6'd56 && !two_ff) begin
               bdata = 8'(bits >> ({3'd7 - pos_ff[2:0], 3'b000}));
            end else begin
               bdata = 8'h00;
            end
            fin_in = 1'b0;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == 6'd63) begin
               state_in = s256hx_pkg::ST_LOAD;
            end
         end
         s256hx_pkg::ST_LOAD: begin
            v_in = h_ff;
            rnd_in = 7'd0;
            state_in = s256hx_pkg::ST_ROUND;
         end
         s256hx_pkg::ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = wr;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 7'd63) begin
               state_in = s256hx_pkg::ST_ADD;
            end
         end
         s256hx_pkg::ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            rnd_in = 7'd0;
            if (two_ff) begin
               two_in = 1'b0;
               pos_in = 6'd0;
               state_in = s256hx_pkg::ST_PAD;
            end else if (fin_ff) begin
               two_in = (cnt_ff[5:0] >= 6'd56);
               pos_in = cnt_ff[5:0];
               state_in = s256hx_pkg::ST_PAD;
            end else begin
               state_in = emit_pending_ff ? s256hx_pkg::ST_EMIT : s256hx_pkg::ST_IDLE;
            end
         end
         s256hx_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff[5:0] == 6'd63) begin
                  h_in = s256hx_pkg::INIT_HASH;
                  cnt_in = '0;
                  state_in = s256hx_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = s256hx_pkg::ST_IDLE;
      endcase
      // block bytes land big-endian in the message words
      if (bwe) begin
         w_in[baddr[5:2]][{~baddr[1:0], 3'b000} +: 8] = bdata;
      end
   end

   always_comb begin
      emit_pending_in = emit_pending_ff;
      if (state_ff == s256hx_pkg::ST_PAD && pos_ff == 6'd63) begin
         emit_pending_in = !two_ff;
      end else if (state_ff == s256hx_pkg::ST_IDLE) begin
         emit_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s256hx_pkg::ST_IDLE;
         cnt_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         emit_pending_ff <= 1'b0;
         h_ff <= s256hx_pkg::INIT_HASH;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
         fin_ff <= fin_in;
         two_ff <= two_in;
         emit_pending_ff <= emit_pending_in;
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

>>> rtl/core/s256hx_checker.sv
// port-level checker for the sha-256 hex digest core
module s256hx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while digest is sent");

   a_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39)
                   || (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h66)))
      else $error("digest word is not a hex digit");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled digest word changed");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("digest continued past last word");

endmodule

bind sha256_hex_digest_core s256hx_checker u_s256hx_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

>>> bench/sha256_hex_digest_core_tb.sv
// self-checking testbench of the streaming sha-256 hex digest core
`timescale 1ns / 100ps

module sha256_hex_digest_core_tb;

   localparam int STALL_PCT  = 21;
   localparam int HANG_LIMIT = 5000;
   localparam int ITEM_GOAL  = 468;

   typedef struct packed {
      logic [6:0] hex;
      logic       last;
   } digest_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // data_byte
   logic [0:0] req_tuser = 1'b0;   // byte_present
   logic       req_tlast = 1'b0;   // message_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // hex_char, bit 7 zero
   logic       rsp_tlast;          // last_char

   sha256_hex_digest_core dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // golden hash state
   logic [31:0]  hash_words [8];
   logic [7:0]   msg_block [64];
   logic [60:0]  msg_count;
   digest_char_type digest_queue [$];

   int  error_count = 0;
   int  words_sent = 0;
   int  messages_done = 0;
   int  chars_seen = 0;
   int  hang_cycles = 0;
   bit  calm = 1'b0;
   bit  running = 1'b0;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, s0, s1, a, e;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = hash_words[i];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wt = w[r];
         end else begin
            a = w[(r + 1) & 15];
            e = w[(r + 14) & 15];
            s0 = rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3);
            s1 = rotr(e, 17) ^ rotr(e, 19) ^ (e >> 10);
            wt = w[r & 15] + s0 + w[(r + 9) & 15] + s1;
            w[r & 15] = wt;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s256hx_pkg::ROUND_K[r] + wt;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_words[i] += v[i];
   endtask

   task automatic absorb_word(logic [7:0] data, logic present, logic fin);
      int pos;
      logic [63:0] bit_len;
      logic [3:0] nib;
      digest_char_type c;
      if (present) begin
         pos = int'(msg_count[5:0]);
         msg_block[pos] = data;
         msg_count = msg_count + 1'b1;
         if (pos == 63) compress_block();
      end
      if (fin) begin
         pos = int'(msg_count[5:0]);
         bit_len = {msg_count, 3'b000};
         msg_block[pos] = 8'h80;
         for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
         if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int k = 0; k < 64; k++) begin
            nib = hash_words[k/8][31-4*(k%8) -: 4];
            c.hex = s256hx_pkg::hex_ascii(nib);
            c.last = (k == 63);
            digest_queue.push_back(c);
         end
         hash_words = s256hx_pkg::INIT_HASH;
         msg_count = '0;
         messages_done++;
      end
   endtask

   task automatic send_word(logic [7:0] data, logic present, logic fin);
      bit took;
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= fin;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      absorb_word(data, present, fin);
      words_sent++;
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         if (i == len - 1 && $urandom_range(1)) begin
            send_word(8'($urandom), 1'b1, 1'b1);
            return;
         end
         send_word(8'($urandom), 1'b1, 1'b0);
      end
      send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_empty_message();
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b1);
   endtask

   task automatic test_flag_mix();
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b0);
      send_word(8'h5a, 1'b0, 1'b1);
      send_word(8'ha5, 1'b1, 1'b1);
   endtask

   task automatic test_pad_boundaries();
      int lens [6] = '{55, 56, 57, 63, 64, 65};
      calm = 1'b1;
      foreach (lens[i]) send_message(lens[i]);
      calm = 1'b0;
   endtask

   task automatic test_random_messages();
      int len;
      while (words_sent < ITEM_GOAL) begin
         case ($urandom_range(3))
            0: len = $urandom_range(3);
            1: len = $urandom_range(54, 66);
            default: len = $urandom_range(130);
         endcase
         if (len > ITEM_GOAL - words_sent) len = ITEM_GOAL - words_sent;
         send_message(len);
      end
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= STALL_PCT);
   end

   always @(negedge clock) begin
      digest_char_type want;
      if (running && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         hang_cycles = 0;
      else if (running)
         hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $realtime, HANG_LIMIT);
         $display("FAIL sha256_hex_digest_core");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_seen++;
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected word, actual %h last %b", $realtime,
                     rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata !== {1'b0, want.hex} || rsp_tlast !== want.last) begin
               $display("%0t: mismatch, expected %h last %b, actual %h last %b",
                        $realtime, {1'b0, want.hex}, want.last, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      hash_words = s256hx_pkg::INIT_HASH;
      msg_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      running = 1'b1;
      @(posedge clock);
      test_empty_message();
      test_flag_mix();
      test_pad_boundaries();
      test_random_messages();
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d messages over %0d words, %0d digest characters checked",
               messages_done, words_sent, chars_seen);
      if (error_count == 0 && digest_queue.size() == 0)
         $display("PASS sha256_hex_digest_core");
      else
         $display("FAIL sha256_hex_digest_core");
      $finish;
   end

endmodule
